### sv/row_major_index_with_bounds_check_assert.svh
// Assertion macros for the row-major index block
`ifndef ROW_MAJOR_INDEX_WITH_BOUNDS_CHECK_ASSERT_SVH
`define ROW_MAJOR_INDEX_WITH_BOUNDS_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
`define RMI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);
`define RMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) else $error(msg);
`else
`define RMI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/rmi_pkg.sv
// Shared types and constants of the row-major index block
package rmi_pkg;

	localparam int NUM_AXES       = 4;
	localparam int SIZE_W         = 12;
	localparam int CNT_W          = 3;
	localparam int STRIDE_W       = 3 * SIZE_W;
	localparam int OFFSET_W       = 48;
	localparam int REG_IDX_W      = 3;
	localparam int ADDR_W         = REG_IDX_W + 2;
	localparam int DATA_W         = 32;
	localparam int DEF_MAX_DIMS   = 4;
	localparam int DEF_INDEX_BITS = 12;

	localparam logic [REG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE0     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SIZE1     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SIZE2     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SIZE3     = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0]  given_count;
		logic [SIZE_W-1:0] index_axis0;
		logic [SIZE_W-1:0] index_axis1;
		logic [SIZE_W-1:0] index_axis2;
		logic [SIZE_W-1:0] index_axis3;
	} in_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] flat_offset;
		logic                count_mismatch;
		logic [NUM_AXES-1:0] axis_out_of_range;
	} out_t;

	typedef struct packed {
		logic                oor;
		logic [OFFSET_W-1:0] prod;
	} lane_res_t;

endpackage

### sv/rmi_lane.sv
// One axis lane: range check and index times stride
module rmi_lane import rmi_pkg::*; (
	input  logic                clk,
	input  logic [SIZE_W-1:0]   idx,
	input  logic [SIZE_W-1:0]   size,
	input  logic                in_use,
	input  logic [STRIDE_W-1:0] stride,
	output lane_res_t           res_s3
);

	logic [OFFSET_W-1:0] prod_c;

	assign prod_c = {{STRIDE_W{1'b0}}, idx} * {{SIZE_W{1'b0}}, stride};

	always_ff @(posedge clk) begin
		res_s3.oor  <= in_use && (idx >= size);
		res_s3.prod <= in_use ? prod_c : '0;
	end

endmodule

### sv/rmi_merge.sv
// Merge stage: sum lane products and assemble the result word
module rmi_merge import rmi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid,
	input  logic      mismatch,
	input  lane_res_t lanes [NUM_AXES],
	output logic      done,
	output out_t      res
);

	logic                valid_s4;
	logic                mis_s4;
	logic [NUM_AXES-1:0] oor_s4;
	logic [OFFSET_W-1:0] sum01_s4;
	logic [OFFSET_W-1:0] sum23_s4;
	logic [NUM_AXES-1:0] oor_c;
	logic                done_q;
	out_t                res_q;

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			oor_c[a] = lanes[a].oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s4 <= valid;
			done_q   <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		mis_s4                  <= mismatch;
		oor_s4                  <= oor_c;
		sum01_s4                <= lanes[0].prod + lanes[1].prod;
		sum23_s4                <= lanes[2].prod + lanes[3].prod;
		res_q.flat_offset       <= sum01_s4 + sum23_s4;
		res_q.count_mismatch    <= mis_s4;
		res_q.axis_out_of_range <= oor_s4;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### sv/row_major_index_with_bounds_check.sv
// Row-major offset generator with per-axis bounds check
//
// Registers are written over the APB port: dim_count at 0x00, the four
// axis sizes at 0x04..0x10. Write only while no request is in flight.
// A request is a word on req, taken at a clock edge with start high and
// busy low. busy stays low, so one request is taken every cycle.
// Each request gives one result word on res, marked by done for a single
// cycle. The receiver cannot stall; a result not taken that cycle is gone.
// The path runs through stride build-up (two multiplier stages), one
// multiplier lane per axis and a two-level adder merge.
// flat_offset is meaningful only when count_mismatch and
// axis_out_of_range are both zero.
// Reset clears the pipeline valid bits, sets dim_count and every axis
// size to 1.
module row_major_index_with_bounds_check import rmi_pkg::*; #(
	parameter int MAX_DIMS   = DEF_MAX_DIMS,
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  in_t               req,
	output logic              done,
	output out_t              res
);

	`include "row_major_index_with_bounds_check_assert.svh"

	localparam int VB  = (INDEX_BITS < SIZE_W) ? INDEX_BITS : SIZE_W;
	localparam int LIM = (MAX_DIMS < NUM_AXES) ? MAX_DIMS : NUM_AXES;
	localparam logic [SIZE_W-1:0] VAL_MASK = SIZE_W'((1 << VB) - 1);
	localparam logic [CNT_W-1:0]  LIM_C    = CNT_W'(LIM);

	logic [CNT_W-1:0]    dim_count_q;
	logic [SIZE_W-1:0]   size_q [NUM_AXES];
	logic                wr_c;
	logic                acc_c;
	logic [CNT_W-1:0]    dims_c;
	logic [NUM_AXES-1:0] use_c;
	logic [SIZE_W-1:0]   size_c [NUM_AXES];
	logic [SIZE_W-1:0]   es_c [NUM_AXES];
	logic [SIZE_W-1:0]   idx_c [NUM_AXES];
	logic [2*SIZE_W-1:0] st23_c;

	logic                valid_s1;
	logic                mis_s1;
	logic [NUM_AXES-1:0] use_s1;
	logic [SIZE_W-1:0]   idx_s1 [NUM_AXES];
	logic [SIZE_W-1:0]   size_s1 [NUM_AXES];
	logic [SIZE_W-1:0]   es1_s1;
	logic [SIZE_W-1:0]   es3_s1;
	logic [2*SIZE_W-1:0] st23_s1;

	logic                valid_s2;
	logic                mis_s2;
	logic [NUM_AXES-1:0] use_s2;
	logic [SIZE_W-1:0]   idx_s2 [NUM_AXES];
	logic [SIZE_W-1:0]   size_s2 [NUM_AXES];
	logic [STRIDE_W-1:0] stride_s2 [NUM_AXES];
	logic [STRIDE_W-1:0] st0_c;

	logic                valid_s3;
	logic                mis_s3;
	lane_res_t           lane_s3 [NUM_AXES];

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_c   = psel && penable && pwrite;
	assign acc_c  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= CNT_W'(1);
			for (int a = 0; a < NUM_AXES; a++) begin
				size_q[a] <= SIZE_W'(1);
			end
		end else if (wr_c) begin
			case (paddr[ADDR_W-1:2])
				REG_DIM_COUNT: dim_count_q <= pwdata[CNT_W-1:0];
				REG_SIZE0:     size_q[0]   <= pwdata[SIZE_W-1:0];
				REG_SIZE1:     size_q[1]   <= pwdata[SIZE_W-1:0];
				REG_SIZE2:     size_q[2]   <= pwdata[SIZE_W-1:0];
				REG_SIZE3:     size_q[3]   <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_DIM_COUNT: prdata = DATA_W'(dim_count_q);
			REG_SIZE0:     prdata = DATA_W'(size_q[0]);
			REG_SIZE1:     prdata = DATA_W'(size_q[1]);
			REG_SIZE2:     prdata = DATA_W'(size_q[2]);
			REG_SIZE3:     prdata = DATA_W'(size_q[3]);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		dims_c = dim_count_q;
		if (dims_c == '0) begin
			dims_c = CNT_W'(1);
		end
		if (dims_c > LIM_C) begin
			dims_c = LIM_C;
		end
	end

	assign idx_c[0] = req.index_axis0 & VAL_MASK;
	assign idx_c[1] = req.index_axis1 & VAL_MASK;
	assign idx_c[2] = req.index_axis2 & VAL_MASK;
	assign idx_c[3] = req.index_axis3 & VAL_MASK;

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			use_c[a]  = CNT_W'(a) < dims_c;
			size_c[a] = size_q[a] & VAL_MASK;
			es_c[a]   = use_c[a] ? size_c[a] : SIZE_W'(1);
		end
	end

	assign st23_c = {{SIZE_W{1'b0}}, es_c[2]} * {{SIZE_W{1'b0}}, es_c[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= acc_c;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mis_s1  <= req.given_count != dims_c;
		use_s1  <= use_c;
		idx_s1  <= idx_c;
		size_s1 <= size_c;
		es1_s1  <= es_c[1];
		es3_s1  <= es_c[3];
		st23_s1 <= st23_c;
	end

	assign st0_c = {{SIZE_W{1'b0}}, st23_s1} * {{2*SIZE_W{1'b0}}, es1_s1};

	always_ff @(posedge clk) begin
		mis_s2       <= mis_s1;
		use_s2       <= use_s1;
		idx_s2       <= idx_s1;
		size_s2      <= size_s1;
		stride_s2[0] <= st0_c;
		stride_s2[1] <= {{SIZE_W{1'b0}}, st23_s1};
		stride_s2[2] <= {{2*SIZE_W{1'b0}}, es3_s1};
		stride_s2[3] <= STRIDE_W'(1);
		mis_s3       <= mis_s2;
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		rmi_lane u_lane (
			.clk    (clk),
			.idx    (idx_s2[a]),
			.size   (size_s2[a]),
			.in_use (use_s2[a]),
			.stride (stride_s2[a]),
			.res_s3 (lane_s3[a])
		);
	end

	rmi_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s3),
		.mismatch (mis_s3),
		.lanes    (lane_s3),
		.done     (done),
		.res      (res)
	);

	`RMI_ASSERT_NEXT(a_req_gives_result, clk, arst_n, start && !busy, ##4 done, "request lost in pipeline")
	`RMI_ASSERT_IMPL(a_result_has_req, clk, arst_n, done, $past(start && !busy, 5), "result without request")
	`RMI_ASSERT_IMPL(a_use_thermo, clk, arst_n, valid_s1, use_s1[0] && ((use_s1 & (use_s1 + NUM_AXES'(1))) == '0), "axis use mask not a run from axis 0")

endmodule

### test/row_major_index_with_bounds_check_tb.sv
// Testbench for the row-major offset generator: directed and random requests checked in order
`timescale 1ns / 100ps

module row_major_index_with_bounds_check_tb;
	import rmi_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int TAIL_CYCLES    = 10;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start   = 1'b0;
	logic              busy;
	in_t               req     = '0;
	logic              done;
	out_t              res;

	logic [CNT_W-1:0]  cfg_dims;
	logic [SIZE_W-1:0] cfg_size [NUM_AXES];
	out_t              offset_q [$];
	out_t              want;
	int                errors       = 0;
	int                stall_cycles = 0;
	bit                steady       = 1'b0;

	row_major_index_with_bounds_check uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.res     (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned active_axes();
		int unsigned d;
		d = cfg_dims;
		if (d < 1) d = 1;
		if (d > DEF_MAX_DIMS) d = DEF_MAX_DIMS;
		if (d > NUM_AXES) d = NUM_AXES;
		return d;
	endfunction

	function automatic out_t predict_offset(in_t r);
		out_t              o;
		logic [SIZE_W-1:0] idx [NUM_AXES];
		logic [OFFSET_W-1:0] stride;
		logic [OFFSET_W-1:0] acc;
		int                a;
		idx[0] = r.index_axis0;
		idx[1] = r.index_axis1;
		idx[2] = r.index_axis2;
		idx[3] = r.index_axis3;
		o = '0;
		stride = 1;
		acc = '0;
		for (a = int'(active_axes()) - 1; a >= 0; a--) begin
			if (idx[a] >= cfg_size[a]) o.axis_out_of_range[a] = 1'b1;
			acc = acc + OFFSET_W'(idx[a]) * stride;
			stride = stride * OFFSET_W'(cfg_size[a]);
		end
		o.flat_offset = acc;
		o.count_mismatch = (r.given_count != CNT_W'(active_axes()));
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (offset_q.size() == 0) begin
				$error("result word with no request pending");
				errors++;
			end else begin
				want = offset_q.pop_front();
				if (res.flat_offset !== want.flat_offset) begin
					$error("flat_offset: expected %0h, got %0h", want.flat_offset, res.flat_offset);
					errors++;
				end
				if (res.count_mismatch !== want.count_mismatch) begin
					$error("count_mismatch: expected %0b, got %0b", want.count_mismatch,
						res.count_mismatch);
					errors++;
				end
				if (res.axis_out_of_range !== want.axis_out_of_range) begin
					$error("axis_out_of_range: expected %b, got %b", want.axis_out_of_range,
						res.axis_out_of_range);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) offset_q.insert(offset_q.size(), predict_offset(req));
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable && pready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic in_t make_item(int unsigned g, int unsigned i0, int unsigned i1,
		int unsigned i2, int unsigned i3);
		in_t r;
		r.given_count = CNT_W'(g);
		r.index_axis0 = SIZE_W'(i0);
		r.index_axis1 = SIZE_W'(i1);
		r.index_axis2 = SIZE_W'(i2);
		r.index_axis3 = SIZE_W'(i3);
		return r;
	endfunction

	function automatic in_t noise_item();
		return make_item($urandom_range(0, 7), $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095));
	endfunction

	function automatic int unsigned pick_index(logic [SIZE_W-1:0] sz);
		int unsigned s;
		int unsigned m;
		s = sz;
		m = $urandom_range(0, 9);
		if (s != 0 && m < 6) return $urandom_range(0, s - 1);
		if (s != 0 && m == 6) return s - 1;
		if (m == 7) return s;
		return $urandom_range(0, 4095);
	endfunction

	function automatic in_t random_item();
		int unsigned eff;
		int unsigned g;
		eff = active_axes();
		if ($urandom_range(0, 99) < 5) return noise_item();
		g = ($urandom_range(0, 99) < 85) ? eff : $urandom_range(0, 7);
		return make_item(g, pick_index(cfg_size[0]), pick_index(cfg_size[1]),
			pick_index(cfg_size[2]), pick_index(cfg_size[3]));
	endfunction

	function automatic int unsigned random_size();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k < 4) return $urandom_range(1, 16);
		if (k < 7) return $urandom_range(1, 4095);
		if (k == 7) return 4095;
		if (k == 8) return 1;
		return $urandom_range(0, 1);
	endfunction

	task automatic send_req(in_t item);
		int gap;
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (!steady && $urandom_range(0, 99) < 4) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			req <= noise_item();
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (offset_q.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] noise;
		noise = $urandom();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= (idx == REG_DIM_COUNT) ? {noise[DATA_W-1:CNT_W], value[CNT_W-1:0]}
			: {noise[DATA_W-1:SIZE_W], value[SIZE_W-1:0]};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_DIM_COUNT: cfg_dims = value[CNT_W-1:0];
			REG_SIZE0: cfg_size[0] = value[SIZE_W-1:0];
			REG_SIZE1: cfg_size[1] = value[SIZE_W-1:0];
			REG_SIZE2: cfg_size[2] = value[SIZE_W-1:0];
			REG_SIZE3: cfg_size[3] = value[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apb_read_check(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== value) begin
			$error("prdata of register %0d: expected %0h, got %0h", idx, value, prdata);
			errors++;
		end
	endtask

	task automatic check_registers();
		apb_read_check(REG_DIM_COUNT, DATA_W'(cfg_dims));
		apb_read_check(REG_SIZE0, DATA_W'(cfg_size[0]));
		apb_read_check(REG_SIZE1, DATA_W'(cfg_size[1]));
		apb_read_check(REG_SIZE2, DATA_W'(cfg_size[2]));
		apb_read_check(REG_SIZE3, DATA_W'(cfg_size[3]));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(int unsigned dims, int unsigned s0, int unsigned s1,
		int unsigned s2, int unsigned s3);
		wait_drained();
		apb_write(REG_DIM_COUNT, DATA_W'(dims));
		apb_write(REG_SIZE0, DATA_W'(s0));
		apb_write(REG_SIZE1, DATA_W'(s1));
		apb_write(REG_SIZE2, DATA_W'(s2));
		apb_write(REG_SIZE3, DATA_W'(s3));
		check_registers();
	endtask

	task automatic test_reset_defaults();
		check_registers();
		send_req(make_item(1, 0, 0, 0, 0));
		send_req(make_item(1, 1, 4095, 4095, 4095));
		send_req(make_item(0, 0, 0, 0, 0));
	endtask

	task automatic test_extremes();
		configure(4, 4095, 4095, 4095, 4095);
		send_req(make_item(4, 0, 0, 0, 0));
		send_req(make_item(4, 4094, 4094, 4094, 4094));
		send_req(make_item(4, 4095, 4095, 4095, 4095));
		send_req(make_item(4, 1, 0, 0, 0));
		send_req(make_item(7, 4094, 0, 4094, 0));
		send_req(make_item(5, 0, 4094, 0, 4094));
	endtask

	task automatic test_dim_saturation();
		configure(0, 5, 7, 9, 11);
		send_req(make_item(1, 4, 4095, 4095, 4095));
		send_req(make_item(0, 5, 0, 0, 0));
		configure(7, 2, 3, 4, 5);
		send_req(make_item(4, 1, 2, 3, 4));
		send_req(make_item(7, 2, 3, 4, 5));
		configure(5, 3, 3, 3, 3);
		send_req(make_item(4, 2, 1, 0, 2));
		send_req(make_item(5, 2, 1, 0, 2));
	endtask

	task automatic test_zero_size();
		configure(3, 6, 5, 0, 9);
		send_req(make_item(3, 2, 3, 0, 8));
		send_req(make_item(3, 1, 1, 4095, 1));
	endtask

	task automatic test_unused_axes();
		configure(2, 10, 20, 1, 1);
		send_req(make_item(2, 9, 19, 4095, 4095));
		send_req(make_item(2, 10, 20, 4095, 4095));
		send_req(make_item(1, 3, 7, 4095, 0));
	endtask

	task automatic test_random_traffic();
		int          sent;
		int          phase;
		int          len;
		int          n;
		int unsigned dims;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			dims = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(0, 7);
			configure(dims, random_size(), random_size(), random_size(), random_size());
			steady = (phase == 2);
			len = steady ? 300 : $urandom_range(40, 140);
			for (n = 0; n < len; n++) send_req(random_item());
			sent += len;
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		cfg_dims = 1;
		for (int a = 0; a < NUM_AXES; a++) cfg_size[a] = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extremes();
		test_dim_saturation();
		test_zero_size();
		test_unused_axes();
		test_random_traffic();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/rmi_pkg.sv
sv/rmi_lane.sv
sv/rmi_merge.sv
sv/row_major_index_with_bounds_check.sv
test/row_major_index_with_bounds_check_tb.sv
